// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is low.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Implication check: when the trigger holds, the consequence holds in the next cycle.
`define CHK_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/mrnd_pkg.sv =====
`timescale 1ns / 1ps

package mrnd_pkg;

    localparam int unsigned SEED_W = 31;
    localparam int unsigned MULT_W = 15;
    localparam int unsigned PROD_W = SEED_W + MULT_W;
    localparam int unsigned CNT_W  = 5;

    localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
    localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

    // Byte address bit that selects the register; start_seed is register 0.
    localparam logic REG_START_SEED = 1'b0;

    typedef logic [SEED_W-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_rem_req;

    typedef struct packed {
        logic  busy;
        logic  done;
        t_word remainder;
    } t_rem_stat;

endpackage

// ===== rtl/mrnd_lcg.sv =====
`timescale 1ns / 1ps

module mrnd_lcg
    import mrnd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_seed,
    output logic  o_done,
    output t_word o_next
);

    logic [PROD_W-1:0] r_prod;
    logic              r_prod_vld;
    logic              r_done;
    t_word             r_next;

    logic [SEED_W:0]   w_sum;
    t_word             w_fold;

    // Modulo 2^31-1: the high part of the product folds back onto the low part.
    always_comb begin
        w_sum = {1'b0, r_prod[SEED_W-1:0]}
              + {{(SEED_W + 1 - MULT_W){1'b0}}, r_prod[PROD_W-1:SEED_W]};
        if (w_sum >= {1'b0, LCG_MOD}) begin
            w_fold = w_sum[SEED_W-1:0] - LCG_MOD;
        end else begin
            w_fold = w_sum[SEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_start;
            r_done     <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= {{MULT_W{1'b0}}, i_seed} * {{SEED_W{1'b0}}, LCG_MULT};
        end
        if (r_prod_vld) begin
            r_next <= w_fold;
        end
    end

    assign o_done = r_done;
    assign o_next = r_next;

endmodule

// ===== rtl/mrnd_rem.sv =====
`timescale 1ns / 1ps

module mrnd_rem
    import mrnd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rem_req  i_req,
    output t_rem_stat o_stat
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_dvd;
    t_word            r_div;

    logic [SEED_W:0]  w_shift;
    logic             w_ge;
    logic [SEED_W:0]  w_diff;
    t_word            n_rem;

    // One restoring step per cycle. A zero divisor always subtracts nothing,
    // so the dividend comes out unchanged.
    always_comb begin
        w_shift = {r_rem, r_dvd[SEED_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
        if (w_ge) begin
            n_rem = w_diff[SEED_W-1:0];
        end else begin
            n_rem = w_shift[SEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SEED_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SEED_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.done      = r_done;
    assign o_stat.remainder = r_rem;

endmodule

// ===== rtl/minstd_bounded_random_core.sv =====
`timescale 1ns / 1ps

// Minimal standard Lehmer generator with a bounded result. Each accepted
// word advances the seed to seed*16807 mod (2^31-1) and returns the new seed
// as o_raw_value and the new seed modulo i_bound as o_random_value (a zero
// bound returns the raw value). Writing start_seed at byte address 0 loads
// the seed at once; 0 and 2^31-1 load as 1. A word passes through the
// multiply, the modulus fold, the bit-per-cycle remainder loop, which sets
// the rate, and the handoff to the output register. o_in_stall is high from
// acceptance until the result has moved into the output register, so the
// next word can enter while a result still waits downstream.
module minstd_bounded_random_core
    import mrnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_bound,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_random_value,
    output logic [30:0] o_raw_value
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LCG  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_word      r_seed;
    t_word      r_start_seed;
    t_word      r_bound;
    logic       r_out_valid;
    t_word      r_out_rand;
    t_word      r_out_raw;

    logic       w_in_acc;
    logic       w_cfg_wr;
    logic       w_out_free;
    logic       w_lcg_done;
    t_word      w_lcg_next;
    t_word      w_wr_seed;
    t_rem_req   w_rem_req;
    t_rem_stat  w_rem_stat;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_START_SEED);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_wr_seed  = pwdata[SEED_W-1:0];

    mrnd_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_seed  (r_seed),
        .o_done  (w_lcg_done),
        .o_next  (w_lcg_next)
    );

    assign w_rem_req.start    = (r_state == S_LCG) && w_lcg_done;
    assign w_rem_req.dividend = w_lcg_next;
    assign w_rem_req.divisor  = r_bound;

    mrnd_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_stat  (w_rem_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LCG;
                end
            end
            S_LCG: begin
                if (w_lcg_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seed       <= SEED_W'(1);
            r_start_seed <= SEED_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_start_seed <= w_wr_seed;
                if (w_wr_seed == '0 || w_wr_seed == LCG_MOD) begin
                    r_seed <= SEED_W'(1);
                end else begin
                    r_seed <= w_wr_seed;
                end
            end else if (w_rem_req.start) begin
                r_seed <= w_lcg_next;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_bound <= i_bound;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_rand <= w_rem_stat.remainder;
            r_out_raw  <= r_seed;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_rand;
    assign o_raw_value    = r_out_raw;
    assign prdata         = {1'b0, r_start_seed};
    assign pready         = 1'b1;

endmodule

// ===== rtl/mrnd_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrnd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [30:0] o_random_value,
    input logic [30:0] o_raw_value
);

    // A held result must keep its word until the sink takes it.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_raw_value) && $stable(o_random_value))

    // The block stays busy right after it takes a word.
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // The raw value always lies inside the generator's cycle.
    `CHK_ALWAYS(a_raw_range, i_clk, i_rst_n, !o_out_valid || (o_raw_value != 31'd0 && o_raw_value != 31'h7FFF_FFFF))

    // A remainder never exceeds its dividend.
    `CHK_ALWAYS(a_rand_le_raw, i_clk, i_rst_n, !o_out_valid || (o_random_value <= o_raw_value))

    `CHK_ALWAYS(a_pready_high, i_clk, i_rst_n, pready)

endmodule

bind minstd_bounded_random_core mrnd_checker u_mrnd_checker (.*);

// ===== bench/tb_minstd_bounded_random_core.sv =====
`timescale 1ns / 1ps

module tb_minstd_bounded_random_core;
    import mrnd_pkg::*;

    localparam logic [2:0] ADDR_START_SEED = 3'd0;
    localparam longint unsigned MINSTD_A = 64'd16807;
    localparam longint unsigned MINSTD_M = 64'd2147483647;
    localparam t_word WORD_MAX = 31'h7FFF_FFFF;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEED_REWRITE_SPAN = 150;

    typedef struct {
        t_word random_value;
        t_word raw_value;
    } draw_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [30:0] i_bound = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [30:0] o_random_value;
    logic [30:0] o_raw_value;

    // Predictor state, kept in step with every accepted word and register write.
    t_word start_seed_reg = 31'd1;
    t_word gen_seed = 31'd1;
    draw_t pending_draws[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    minstd_bounded_random_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_bound        (i_bound),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value),
        .o_raw_value    (o_raw_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The seed values 0 and 2^31-1 are off the generator's cycle and load as 1.
    function automatic t_word seed_sanitized(input t_word s);
        if (s == '0 || s == WORD_MAX) begin
            return t_word'(1);
        end
        return s;
    endfunction

    function automatic t_word minstd_advance(input t_word s);
        longint unsigned prod;
        prod = s;
        prod = prod * MINSTD_A;
        return t_word'(prod % MINSTD_M);
    endfunction

    function automatic t_word next_raw_peek();
        return minstd_advance(seed_sanitized(gen_seed));
    endfunction

    function automatic t_word pick_bound();
        t_word next_raw;
        next_raw = next_raw_peek();
        case ($urandom_range(11))
            0: begin
                return '0;
            end
            1, 2: begin
                return t_word'($urandom_range(1, 16));
            end
            3: begin
                return t_word'($urandom_range(1, 65535));
            end
            4: begin
                return t_word'(1) << $urandom_range(30);
            end
            5: begin
                return (t_word'(1) << $urandom_range(1, 31)) - t_word'(1);
            end
            6: begin
                // Just below, equal to, or just above the coming raw value.
                return next_raw + t_word'($urandom_range(2)) - t_word'(1);
            end
            default: begin
                return t_word'($urandom);
            end
        endcase
    endfunction

    task automatic write_start_seed(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_START_SEED;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        start_seed_reg = value[30:0];
        gen_seed = seed_sanitized(start_seed_reg);
    endtask

    // Offers one word and records its expected result at the edge that takes it.
    task automatic send_bound(input t_word bound);
        draw_t d;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bound <= bound;
        do @(posedge i_clk); while (o_in_stall);
        gen_seed = minstd_advance(seed_sanitized(gen_seed));
        d.raw_value = gen_seed;
        d.random_value = (bound == '0) ? gen_seed : gen_seed % bound;
        pending_draws.push_back(d);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_seed();
        send_bound('0);
        send_bound(t_word'(1));
        send_bound(WORD_MAX);
        send_bound(next_raw_peek());
        send_bound(next_raw_peek() + t_word'(1));
        wait_drained();
    endtask

    task automatic test_bound_patterns();
        write_start_seed(32'h7FFF_FFFE);
        send_bound(t_word'(2));
        send_bound(t_word'(3));
        send_bound(31'h5555_5555);
        send_bound(31'h2AAA_AAAA);
        send_bound(31'h4000_0000);
        send_bound(WORD_MAX - t_word'(1));
        wait_drained();
        write_start_seed(32'h0000_0001);
        send_bound(t_word'(7));
        wait_drained();
    endtask

    task automatic test_degenerate_seeds();
        logic [31:0] seeds [4];
        seeds = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0005};
        foreach (seeds[k]) begin
            write_start_seed(seeds[k]);
            send_bound(WORD_MAX);
            send_bound(t_word'(10));
            wait_drained();
        end
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if (i % SEED_REWRITE_SPAN == SEED_REWRITE_SPAN - 1) begin
                wait_drained();
                write_start_seed(($urandom_range(3) == 0) ? 32'h7FFF_FFFE : $urandom);
            end
            send_bound(pick_bound());
        end
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 400;
        for (int i = 0; i < 12; i++) begin
            send_bound(pick_bound());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        draw_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected word: random_value %0d, raw_value %0d",
                       o_random_value, o_raw_value);
                mismatches++;
            end else begin
                want = pending_draws.pop_front();
                if (o_random_value !== want.random_value) begin
                    $error("random_value: expected %0d, got %0d",
                           want.random_value, o_random_value);
                    mismatches++;
                end
                if (o_raw_value !== want.raw_value) begin
                    $error("raw_value: expected %0d, got %0d", want.raw_value, o_raw_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_seed();
        test_bound_patterns();
        test_degenerate_seeds();
        test_random(31, 52, 450);
        test_random(52, 31, 450);
        test_random(0, 0, 450);
        test_backpressure();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
